/* rtl/srrq_pkg.sv */
// Shared types, codes and default sizes for the striped round-robin queue.
package srrq_pkg;

  // Default sizes handed down from the top level.
  localparam int unsigned QUEUES_DEF     = 4;
  localparam int unsigned LANE_DEPTH_DEF = 16;
  localparam int unsigned WORD_BITS_DEF  = 32;

  // Fixed port widths of the item and result fields.
  localparam int unsigned ITEM_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned LANE_O_W = 2;

  // Request codes.
  localparam logic REQ_ENQ = 1'b0;
  localparam logic REQ_DEQ = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_PICK,
    S_ACCESS,
    S_OUT
  } state_t;

  // Update command from the sequencer to the lane pointer unit.
  typedef struct packed {
    logic push;
    logic pop;
  } lane_cmd_t;

endpackage

/* rtl/srrq_ram.sv */
// Generic single-port RAM with registered read data.
module srrq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // One access per cycle: write, or read into the output register.
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem_r[addr] <= wdata;
      end else begin
        rdata_r <= mem_r[addr];
      end
    end
  end

endmodule

/* rtl/srrq_lane_ctl.sv */
// Per-lane head and fill-count state, pointer arithmetic and the dequeue scan.
module srrq_lane_ctl #(
  parameter int unsigned QUEUES     = srrq_pkg::QUEUES_DEF,
  parameter int unsigned LANE_DEPTH = srrq_pkg::LANE_DEPTH_DEF,
  parameter int unsigned LANE_W     = (QUEUES > 1) ? $clog2(QUEUES) : 1,
  parameter int unsigned PTR_W      = $clog2(LANE_DEPTH)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  srrq_pkg::lane_cmd_t cmd,
  input  logic [LANE_W-1:0] cmd_lane,
  input  logic              rd_head,
  output logic [PTR_W-1:0]  ptr,
  output logic [QUEUES-1:0] full_vec,
  input  logic [LANE_W-1:0] scan_start,
  output logic              scan_found,
  output logic [LANE_W-1:0] scan_lane,
  output logic              any_pending
);
  import srrq_pkg::*;

  localparam int unsigned CNT_W = $clog2(LANE_DEPTH + 1);

  logic [PTR_W-1:0]    head_r  [QUEUES];
  logic [CNT_W-1:0]    count_r [QUEUES];
  logic [PTR_W-1:0]    head_sel;
  logic [CNT_W-1:0]    count_sel;
  logic [PTR_W:0]      tail_sum;
  logic [PTR_W-1:0]    tail;
  logic [PTR_W-1:0]    head_inc;
  logic [QUEUES-1:0]   ne_vec;
  logic [2*QUEUES-1:0] ne_rot;
  logic [LANE_W-1:0]   scan_ofs;
  logic [LANE_W:0]     scan_sum;

  // Selected lane's pointers; tail is head plus count wrapped once.
  always_comb begin
    head_sel  = head_r[cmd_lane];
    count_sel = count_r[cmd_lane];
    tail_sum  = {1'b0, head_sel} + (PTR_W + 1)'(count_sel);
    if (tail_sum >= (PTR_W + 1)'(LANE_DEPTH)) begin
      tail = PTR_W'(tail_sum - (PTR_W + 1)'(LANE_DEPTH));
    end else begin
      tail = tail_sum[PTR_W-1:0];
    end
    if (head_sel == PTR_W'(LANE_DEPTH - 1)) begin
      head_inc = '0;
    end else begin
      head_inc = head_sel + PTR_W'(1);
    end
    ptr = rd_head ? head_sel : tail;
  end

  // Per-lane status flags.
  always_comb begin
    for (int i = 0; i < QUEUES; i++) begin
      ne_vec[i]   = (count_r[i] != '0);
      full_vec[i] = (count_r[i] == CNT_W'(LANE_DEPTH));
    end
    any_pending = |ne_vec;
  end

  // Rotate-priority scan: first non-empty lane at or after the start lane.
  always_comb begin
    ne_rot     = {ne_vec, ne_vec} >> scan_start;
    scan_found = 1'b0;
    scan_ofs   = '0;
    for (int i = QUEUES - 1; i >= 0; i--) begin
      if (ne_rot[i]) begin
        scan_found = 1'b1;
        scan_ofs   = LANE_W'(i);
      end
    end
    scan_sum = {1'b0, scan_start} + {1'b0, scan_ofs};
    if (scan_sum >= (LANE_W + 1)'(QUEUES)) begin
      scan_lane = LANE_W'(scan_sum - (LANE_W + 1)'(QUEUES));
    end else begin
      scan_lane = scan_sum[LANE_W-1:0];
    end
  end

  // Pointer and count update for the selected lane.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < QUEUES; i++) begin
        head_r[i]  <= '0;
        count_r[i] <= '0;
      end
    end else if (cmd.push) begin
      count_r[cmd_lane] <= count_sel + CNT_W'(1);
    end else if (cmd.pop) begin
      head_r[cmd_lane]  <= head_inc;
      count_r[cmd_lane] <= count_sel - CNT_W'(1);
    end
  end

endmodule

/* rtl/striped_round_robin_queue_top.sv */
// Top level of the striped round-robin queue: sequencer, turns and lane memory.
//
// A command is taken when start is high and busy is low. Its result appears
// after the pick and access steps with out_valid high for exactly one cycle;
// the receiver cannot stall and must take it then. A new command may be issued
// in the same cycle as that strobe, but not while an earlier one is in flight.
// The three steps are: pick the lane (enqueue turn, or a rotate-priority scan
// over the per-lane fill counts for a dequeue), form the lane memory address
// and do the write or read, then present the registered read data. The lane
// memory needs no clearing after reset; only written entries are ever read.
module striped_round_robin_queue_top #(
  parameter int unsigned QUEUES     = srrq_pkg::QUEUES_DEF,
  parameter int unsigned LANE_DEPTH = srrq_pkg::LANE_DEPTH_DEF,
  parameter int unsigned WORD_BITS  = srrq_pkg::WORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic                            in_req_type,
  input  logic [srrq_pkg::ITEM_W-1:0]     in_item_word,
  output logic                            out_valid,
  output logic [srrq_pkg::ITEM_W-1:0]     out_out_word,
  output logic [srrq_pkg::STATUS_W-1:0]   out_status,
  output logic [srrq_pkg::LANE_O_W-1:0]   out_lane_used,
  output logic                            out_any_pending
);
  import srrq_pkg::*;

  localparam int unsigned LANE_W = (QUEUES > 1) ? $clog2(QUEUES) : 1;
  localparam int unsigned PTR_W  = $clog2(LANE_DEPTH);
  localparam int unsigned DEPTH  = QUEUES * LANE_DEPTH;
  localparam int unsigned ADDR_W = $clog2(DEPTH);

  state_t                state_r, state_nxt;
  logic                  req_r, req_nxt;
  logic [WORD_BITS-1:0]  word_r, word_nxt;
  logic [LANE_W-1:0]     lane_r, lane_nxt;
  logic [STATUS_W-1:0]   status_r, status_nxt;
  logic [LANE_W-1:0]     enq_turn_r, enq_turn_nxt;
  logic [LANE_W-1:0]     deq_turn_r, deq_turn_nxt;

  logic                  accept;
  lane_cmd_t             cmd;
  logic [PTR_W-1:0]      ptr;
  logic [QUEUES-1:0]     full_vec;
  logic                  scan_found;
  logic [LANE_W-1:0]     scan_lane;
  logic                  any_pending;
  logic [ADDR_W-1:0]     ram_addr;
  logic                  ram_en;
  logic [WORD_BITS-1:0]  ram_rdata;
  logic [WORD_BITS+ITEM_W-1:0] in_ext;
  logic [WORD_BITS+ITEM_W-1:0] rd_ext;
  logic [LANE_W+LANE_O_W-1:0]  lane_ext;

  assign accept = start && !busy;

  // Lane pointer unit.
  srrq_lane_ctl #(
    .QUEUES     (QUEUES),
    .LANE_DEPTH (LANE_DEPTH),
    .LANE_W     (LANE_W),
    .PTR_W      (PTR_W)
  ) u_lane_ctl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .cmd_lane    (lane_r),
    .rd_head     (req_r),
    .ptr         (ptr),
    .full_vec    (full_vec),
    .scan_start  (deq_turn_r),
    .scan_found  (scan_found),
    .scan_lane   (scan_lane),
    .any_pending (any_pending)
  );

  // Lane memory: lane-major, one word per entry.
  assign ram_addr = ADDR_W'(lane_r) * ADDR_W'(LANE_DEPTH) + ADDR_W'(ptr);
  assign ram_en   = cmd.push || cmd.pop;

  srrq_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .en      (ram_en),
    .we      (cmd.push),
    .addr    (ram_addr),
    .wdata   (word_r),
    .rdata_r (ram_rdata)
  );

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   state_nxt = start ? S_PICK : S_IDLE;
      S_PICK:   state_nxt = S_ACCESS;
      S_ACCESS: state_nxt = S_OUT;
      S_OUT:    state_nxt = start ? S_PICK : S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    busy      = 1'b1;
    out_valid = 1'b0;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        busy = 1'b0;
      end
      S_PICK: begin
      end
      S_ACCESS: begin
        cmd.push = (req_r == REQ_ENQ) && (status_r == ST_OK);
        cmd.pop  = (req_r == REQ_DEQ) && (status_r == ST_OK);
      end
      S_OUT: begin
        busy      = 1'b0;
        out_valid = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Item capture, lane pick and turn advance.
  always_comb begin
    in_ext       = {{WORD_BITS{1'b0}}, in_item_word};
    req_nxt      = req_r;
    word_nxt     = word_r;
    lane_nxt     = lane_r;
    status_nxt   = status_r;
    enq_turn_nxt = enq_turn_r;
    deq_turn_nxt = deq_turn_r;
    if (accept) begin
      req_nxt  = in_req_type;
      word_nxt = in_ext[WORD_BITS-1:0];
    end
    if (state_r == S_PICK) begin
      if (req_r == REQ_DEQ) begin
        lane_nxt   = scan_found ? scan_lane : '0;
        status_nxt = scan_found ? ST_OK : ST_EMPTY;
      end else begin
        lane_nxt   = enq_turn_r;
        status_nxt = full_vec[enq_turn_r] ? ST_FULL : ST_OK;
      end
    end
    if (state_r == S_ACCESS) begin
      if (req_r == REQ_DEQ) begin
        deq_turn_nxt = (deq_turn_r == LANE_W'(QUEUES - 1)) ? '0 : deq_turn_r + LANE_W'(1);
      end else begin
        enq_turn_nxt = (enq_turn_r == LANE_W'(QUEUES - 1)) ? '0 : enq_turn_r + LANE_W'(1);
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      enq_turn_r <= '0;
      deq_turn_r <= '0;
    end else begin
      state_r    <= state_nxt;
      enq_turn_r <= enq_turn_nxt;
      deq_turn_r <= deq_turn_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    req_r    <= req_nxt;
    word_r   <= word_nxt;
    lane_r   <= lane_nxt;
    status_r <= status_nxt;
  end

  // Result fields.
  always_comb begin
    rd_ext   = {{ITEM_W{1'b0}}, ram_rdata};
    lane_ext = {{LANE_O_W{1'b0}}, lane_r};
    if ((req_r == REQ_DEQ) && (status_r == ST_OK)) begin
      out_out_word = rd_ext[ITEM_W-1:0];
    end else begin
      out_out_word = '0;
    end
    out_status      = status_r;
    out_lane_used   = lane_ext[LANE_O_W-1:0];
    out_any_pending = any_pending;
  end

`ifndef SYNTHESIS
  // Every accepted item produces its result strobe after the pick and access steps.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##3 out_valid)
    else $error("result strobe missing three cycles after accept");

  // A strobe is never followed directly by another.
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("back-to-back result strobes");

  // A dequeue that found every lane empty leaves every lane empty.
  a_empty_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_EMPTY) |-> !out_any_pending)
    else $error("empty dequeue reported pending data");

  // An enqueue that stored its word always leaves data pending.
  a_enq_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && req_r == REQ_ENQ && out_status == ST_OK) |-> out_any_pending)
    else $error("stored enqueue left no pending data");

  // Memory is touched only during the access step.
  a_ram_step: assert property (@(posedge clk) disable iff (!rst_n)
    ram_en |-> (state_r == S_ACCESS))
    else $error("lane memory accessed outside the access step");
`endif

endmodule
